### design/chacha_pkg.sv
package chacha_pkg;

   localparam int DOUBLE_ROUNDS_DEF = 10;

   localparam int KEY_W   = 64;
   localparam int WORD_W  = 32;
   localparam int NWORDS  = 16;
   localparam int CSR_IDX_W = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MIDLOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MIDHIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE       = 3'd4;

   // "expand 32-byte k"
   localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

   typedef struct packed {
      logic [31:0] msg_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic [2:0]  out_valid_bytes;
      logic        out_last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic round;
      logic finish;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic buffer_full;
      logic last_step;
      logic out_busy;
   } status_type;

endpackage

### design/chacha_ctrl.sv
module chacha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  chacha_pkg::status_type status,
   output chacha_pkg::cmd_type    cmd
);
   import chacha_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.buffer_full ? ST_EMIT : ST_LOAD;
            end
         end
         ST_LOAD:   state_in = ST_ROUND;
         ST_ROUND: begin
            if (status.last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.accept = 1'b1;
         ST_LOAD:   cmd.load   = 1'b1;
         ST_ROUND:  cmd.round  = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         ST_EMIT:   cmd.emit   = !status.out_busy;
         default:   cmd = '0;
      endcase
   end

endmodule

### design/chacha_datapath.sv
module chacha_datapath #(
   parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [chacha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [chacha_pkg::KEY_W-1:0]        csr_wdata,
   input  logic                                req_valid,
   input  chacha_pkg::req_payload_type         req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output chacha_pkg::rsp_payload_type         rsp_data,
   input  chacha_pkg::cmd_type                 cmd,
   output chacha_pkg::status_type              status
);
   import chacha_pkg::*;

   localparam int STEPS  = 4 * DOUBLE_ROUNDS;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

   logic [KEY_W-1:0] key_low_ff, key_midlow_ff, key_midhigh_ff, key_high_ff, nonce_ff;
   logic [63:0]      counter_ff, counter_in;
   logic [3:0]       pos_ff, pos_in;
   logic             full_ff, full_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] x_ff [NWORDS];
   logic [WORD_W-1:0] x_in [NWORDS];
   logic [WORD_W-1:0] init [NWORDS];
   req_payload_type  in_ff;
   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] ks;
   logic [WORD_W-1:0] mask;

   // half of a quarter round; second selects the 8/7 rotations
   function automatic logic [127:0] half_qr(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c, logic [31:0] d,
                                            logic second);
      logic [31:0] na, nb, nc, nd, t, u;
      na = a + b;
      t  = d ^ na;
      nd = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
      nc = c + nd;
      u  = b ^ nc;
      nb = second ? {u[24:0], u[31:25]} : {u[19:0], u[31:20]};
      return {na, nb, nc, nd};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff     <= '0;
         key_midlow_ff  <= '0;
         key_midhigh_ff <= '0;
         key_high_ff    <= '0;
         nonce_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW:     key_low_ff     <= csr_wdata;
            CSR_KEY_MIDLOW:  key_midlow_ff  <= csr_wdata;
            CSR_KEY_MIDHIGH: key_midhigh_ff <= csr_wdata;
            CSR_KEY_HIGH:    key_high_ff    <= csr_wdata;
            CSR_NONCE:       nonce_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      init[0]  = SIGMA0;
      init[1]  = SIGMA1;
      init[2]  = SIGMA2;
      init[3]  = SIGMA3;
      init[4]  = key_low_ff[31:0];
      init[5]  = key_low_ff[63:32];
      init[6]  = key_midlow_ff[31:0];
      init[7]  = key_midlow_ff[63:32];
      init[8]  = key_midhigh_ff[31:0];
      init[9]  = key_midhigh_ff[63:32];
      init[10] = key_high_ff[31:0];
      init[11] = key_high_ff[63:32];
      init[12] = counter_ff[31:0];
      init[13] = counter_ff[63:32];
      init[14] = nonce_ff[31:0];
      init[15] = nonce_ff[63:32];
   end

   // step bit 0: which half of the quarter round, bit 1: column or diagonal
   always_comb begin
      for (int i = 0; i < NWORDS; i++) begin
         x_in[i] = x_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < NWORDS; i++) begin
            x_in[i] = init[i];
         end
      end else if (cmd.round) begin
         if (!step_ff[1]) begin
            for (int l = 0; l < 4; l++) begin
               {x_in[l], x_in[4+l], x_in[8+l], x_in[12+l]} =
                  half_qr(x_ff[l], x_ff[4+l], x_ff[8+l], x_ff[12+l], step_ff[0]);
            end
         end else begin
            for (int l = 0; l < 4; l++) begin
               {x_in[l], x_in[4+((l+1)%4)], x_in[8+((l+2)%4)], x_in[12+((l+3)%4)]} =
                  half_qr(x_ff[l], x_ff[4+((l+1)%4)], x_ff[8+((l+2)%4)],
                          x_ff[12+((l+3)%4)], step_ff[0]);
            end
         end
      end else if (cmd.finish) begin
         for (int i = 0; i < NWORDS; i++) begin
            x_in[i] = x_ff[i] + init[i];
         end
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.load) begin
         step_in = '0;
      end else if (cmd.round) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   assign ks = x_ff[pos_ff];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mask[8*k +: 8] = {8{in_ff.valid_bytes > 3'(k)}};
      end
   end

   always_comb begin
      counter_in   = counter_ff;
      pos_in       = pos_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.finish) begin
         counter_in = counter_ff + 64'd1;
         pos_in     = '0;
         full_in    = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.out_word        = (in_ff.msg_word ^ ks) & mask;
         rsp_data_in.out_valid_bytes = in_ff.valid_bytes;
         rsp_data_in.out_last        = in_ff.last_word;
         pos_in                      = pos_ff + 4'd1;
         if (pos_ff == 4'd15) begin
            full_in = 1'b0;
         end
         // message ends: restart at block zero
         if (in_ff.last_word) begin
            counter_in = '0;
            pos_in     = '0;
            full_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NWORDS; i++) begin
         x_ff[i] <= x_in[i];
      end
      rsp_data_ff <= rsp_data_in;
      if (cmd.accept && req_valid) begin
         in_ff <= req_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign status.buffer_full = full_ff;
   assign status.last_step   = (step_ff == STEP_LAST);
   assign status.out_busy    = rsp_valid_ff && rsp_stall;

endmodule

### design/chacha20_stream_xor.sv
// ChaCha20 stream XOR, original layout (64-bit nonce, 64-bit block counter
// starting at zero for each message). Each transaction carries one
// little-endian message word and returns it XORed with the next keystream
// word; bytes beyond valid_bytes come back zero. While a keystream block is
// held a word is accepted and then emitted; the emit waits while the last
// result is stalled in the output register. A word that needs a new block
// goes through a load step, then four quarter-round lanes doing half a
// quarter round per cycle, then the final feed-forward add, before its emit.
// A result waits in its output register while the next word is accepted.
// Write the key and nonce registers only between messages.
module chacha20_stream_xor #(
   parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [chacha_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [chacha_pkg::KEY_W-1:0]     csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  chacha_pkg::req_payload_type      req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output chacha_pkg::rsp_payload_type      rsp_data
);
   import chacha_pkg::*;

   cmd_type    cmd;
   status_type status;

   chacha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   chacha_datapath #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_stall = !cmd.accept;

endmodule
